// ===== rtl/core/frame_builder_with_crc16_assert.svh =====
// Assertion macros for the frame builder.
// Macros expect clk and arst_n in scope; empty when SYNTHESIS is defined.
`ifndef FRAME_BUILDER_WITH_CRC16_ASSERT_SVH
`define FRAME_BUILDER_WITH_CRC16_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define FBC_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("fbc assertion failed");
// next-cycle implication
`define FBC_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("fbc assertion failed");
`else
`define FBC_ASSERT_SAME(lbl, pre, post)
`define FBC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/core/fbc_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the frame builder.
// No dependencies.
package fbc_pkg;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam int unsigned HDR_LEN = 8;
	localparam int unsigned CRC_LEN = 2;

	localparam int unsigned CQ_DEPTH = 4;
	localparam int unsigned CQ_AW = 2;

	// command kinds
	localparam logic [1:0] K_ERR = 2'd0;
	localparam logic [1:0] K_START = 2'd1;
	localparam logic [1:0] K_DATA = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_TOO_LONG = 3'd1;
	localparam logic [2:0] ST_OVER_CAP = 3'd2;
	localparam logic [2:0] ST_STRAY = 3'd3;
	localparam logic [2:0] ST_BUSY = 3'd4;

	// request types
	localparam logic REQ_START = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_MAGIC_FIRST = 2'd0;
	localparam logic [1:0] CFG_MAGIC_SECOND = 2'd1;
	localparam logic [1:0] CFG_VERSION = 2'd2;
	localparam logic [1:0] CFG_CAPACITY = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] status;
		logic [7:0] data;
		logic [15:0] seq;
		logic [15:0] plen;
		logic close;
		logic [8:0] flen;
	} cmd_t;

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic [2:0] status;
		logic [8:0] flen;
	} res_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/fbc_front.sv =====
// Front end: classifies each accepted item, tracks the open frame and
// builds one command per item. Depends on fbc_pkg.
module fbc_front import fbc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input logic clk,
	input logic arst_n,
	input logic accept,
	input logic req_type,
	input logic [7:0] frame_type,
	input logic [15:0] sequence_number,
	input logic [15:0] payload_length,
	input logic [7:0] payload_byte,
	input logic [15:0] buffer_capacity,
	output cmd_t cmd
);

	localparam int unsigned RW = $clog2(MAX_PAYLOAD + 1);

	logic frame_open_q;
	logic [RW-1:0] remaining_q;
	logic [8:0] flen_q;

	logic [16:0] total;
	logic too_long;
	logic over_cap;

	assign total = {1'b0, payload_length} + 17'(HDR_LEN + CRC_LEN);
	assign too_long = {1'b0, payload_length} > 17'(MAX_PAYLOAD);
	assign over_cap = {1'b0, buffer_capacity} < total;

	always_comb begin
		cmd = '0;
		cmd.seq = sequence_number;
		cmd.plen = payload_length;
		if (req_type == REQ_START) begin
			cmd.data = frame_type;
			if (frame_open_q) begin
				cmd.kind = K_ERR;
				cmd.status = ST_BUSY;
			end else if (too_long) begin
				cmd.kind = K_ERR;
				cmd.status = ST_TOO_LONG;
			end else if (over_cap) begin
				cmd.kind = K_ERR;
				cmd.status = ST_OVER_CAP;
			end else begin
				cmd.kind = K_START;
				cmd.close = (payload_length == 16'd0);
				cmd.flen = total[8:0];
			end
		end else begin
			cmd.data = payload_byte;
			if (!frame_open_q || remaining_q == '0) begin
				cmd.kind = K_ERR;
				cmd.status = ST_STRAY;
			end else begin
				cmd.kind = K_DATA;
				cmd.close = (remaining_q == RW'(1));
				cmd.flen = flen_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			remaining_q <= '0;
			flen_q <= '0;
		end else if (accept) begin
			if (cmd.kind == K_START) begin
				frame_open_q <= !cmd.close;
				remaining_q <= payload_length[RW-1:0];
				flen_q <= total[8:0];
			end else if (cmd.kind == K_DATA) begin
				remaining_q <= remaining_q - RW'(1);
				if (cmd.close) begin
					frame_open_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== rtl/core/fbc_cmd_queue.sv =====
// Short command queue between front and back end.
// Depends on fbc_pkg.
module fbc_cmd_queue import fbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cmd_t push_cmd,
	input logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t entries_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0] count_q;
	logic do_push;
	logic do_pop;

	assign full = (count_q == (CQ_AW + 1)'(CQ_DEPTH));
	assign empty = (count_q == '0);
	assign head = entries_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + CQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + CQ_AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (CQ_AW + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (CQ_AW + 1)'(1);
			end
		end
	end

endmodule

// ===== rtl/core/fbc_back.sv =====
// Back end: expands commands into output beats, runs the CRC and holds a
// two-entry result buffer. Depends on fbc_pkg.
module fbc_back import fbc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input cmd_t cmd,
	output logic cmd_pop,
	input logic [7:0] magic_first,
	input logic [7:0] magic_second,
	input logic [7:0] protocol_version,
	output logic empty,
	input logic pop,
	output logic [7:0] out_byte,
	output logic last_byte,
	output logic [2:0] status,
	output logic [8:0] frame_length
);

	logic [3:0] idx_q;
	logic [15:0] crc_q;

	res_t buf_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;

	logic is_err, is_start, is_data;
	logic crc_lo, crc_hi, data_beat, end_of_cmd;
	logic [7:0] beat_byte;
	logic [15:0] crc_base;
	logic out_pop, space, fire;
	res_t beat;

	assign is_err = (cmd.kind == K_ERR);
	assign is_start = (cmd.kind == K_START);
	assign is_data = (cmd.kind == K_DATA);

	assign crc_lo = (is_start && idx_q == 4'd8) || (is_data && idx_q == 4'd1);
	assign crc_hi = (is_start && idx_q == 4'd9) || (is_data && idx_q == 4'd2);
	assign data_beat = !is_err && !crc_lo && !crc_hi;
	assign end_of_cmd = is_err
		|| (is_start && (cmd.close ? idx_q == 4'd9 : idx_q == 4'd7))
		|| (is_data && (cmd.close ? idx_q == 4'd2 : idx_q == 4'd0));

	always_comb begin
		case (idx_q)
			4'd0: beat_byte = magic_first;
			4'd1: beat_byte = magic_second;
			4'd2: beat_byte = protocol_version;
			4'd3: beat_byte = cmd.data;
			4'd4: beat_byte = cmd.seq[7:0];
			4'd5: beat_byte = cmd.seq[15:8];
			4'd6: beat_byte = cmd.plen[7:0];
			4'd7: beat_byte = cmd.plen[15:8];
			default: beat_byte = 8'h00;
		endcase
		if (is_data) begin
			beat_byte = cmd.data;
		end
	end

	// header restarts the CRC on its first beat
	assign crc_base = (is_start && idx_q == 4'd0) ? CRC_INIT : crc_q;

	always_comb begin
		beat = '0;
		if (is_err) begin
			beat.last = 1'b1;
			beat.status = cmd.status;
		end else if (crc_lo) begin
			beat.data = crc_q[7:0];
		end else if (crc_hi) begin
			beat.data = crc_q[15:8];
			beat.last = 1'b1;
			beat.flen = cmd.flen;
		end else begin
			beat.data = beat_byte;
		end
	end

	assign out_pop = pop && (count_q != 2'd0);
	assign space = (count_q != 2'd2) || out_pop;
	assign fire = cmd_valid && space;
	assign cmd_pop = fire && end_of_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			crc_q <= CRC_INIT;
		end else if (fire) begin
			idx_q <= end_of_cmd ? 4'd0 : idx_q + 4'd1;
			if (data_beat) begin
				crc_q <= crc_byte(crc_base, beat_byte);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			buf_q[wr_ptr_q] <= beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (fire) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (out_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (fire && !out_pop) begin
				count_q <= count_q + 2'd1;
			end else if (out_pop && !fire) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	assign empty = (count_q == 2'd0);
	assign out_byte = buf_q[rd_ptr_q].data;
	assign last_byte = buf_q[rd_ptr_q].last;
	assign status = buf_q[rd_ptr_q].status;
	assign frame_length = buf_q[rd_ptr_q].flen;

endmodule

// ===== rtl/core/frame_builder_with_crc16.sv =====
// Frame builder with CRC-16/CCITT-FALSE trailer.
// Items pass the command queue entry, then the result buffer, to the ports.
// Throughput: one item per cycle in unless full, one beat per cycle out when
// buffer has space; a start item is 8 or 10 beats, so back-end rate sets pace.
// Reset (arst_n, async): no frame open, queues empty, CRC 0xFFFF,
// magic/version 0, capacity 0xFFFF. Depends on fbc_pkg and the assert header.
`include "frame_builder_with_crc16_assert.svh"
module frame_builder_with_crc16 import fbc_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 256
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic req_type,
	input logic [7:0] frame_type,
	input logic [15:0] sequence_number,
	input logic [15:0] payload_length,
	input logic [7:0] payload_byte,
	output logic empty,
	input logic pop,
	output logic [7:0] out_byte,
	output logic last_byte,
	output logic [2:0] status,
	output logic [8:0] frame_length,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);

	logic [7:0] magic_first_q;
	logic [7:0] magic_second_q;
	logic [7:0] version_q;
	logic [15:0] capacity_q;

	logic accept;
	logic cq_full, cq_empty, cq_pop;
	cmd_t front_cmd, head_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_first_q <= '0;
			magic_second_q <= '0;
			version_q <= '0;
			capacity_q <= 16'hFFFF;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MAGIC_FIRST: magic_first_q <= cfg_data[7:0];
				CFG_MAGIC_SECOND: magic_second_q <= cfg_data[7:0];
				CFG_VERSION: version_q <= cfg_data[7:0];
				CFG_CAPACITY: capacity_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign full = cq_full;
	assign accept = push && !cq_full;

	fbc_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.req_type(req_type),
		.frame_type(frame_type),
		.sequence_number(sequence_number),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.buffer_capacity(capacity_q),
		.cmd(front_cmd)
	);

	fbc_cmd_queue u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.push(accept),
		.push_cmd(front_cmd),
		.pop(cq_pop),
		.full(cq_full),
		.empty(cq_empty),
		.head(head_cmd)
	);

	fbc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(!cq_empty),
		.cmd(head_cmd),
		.cmd_pop(cq_pop),
		.magic_first(magic_first_q),
		.magic_second(magic_second_q),
		.protocol_version(version_q),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.last_byte(last_byte),
		.status(status),
		.frame_length(frame_length)
	);

	// an accepted item is queued for the back end
	`FBC_ASSERT_NEXT(a_cmd_queued, accept, !cq_empty)
	// error results carry no byte and no length
	`FBC_ASSERT_SAME(a_err_shape, !empty && status != ST_OK,
		last_byte && out_byte == 8'h00 && frame_length == 9'd0)
	// a length is only reported on the closing beat
	`FBC_ASSERT_SAME(a_len_on_last, !empty && frame_length != 9'd0, last_byte)

endmodule
